// ----- rtl/bmh_pkg.sv -----
// bmh_pkg: shared types and constants of the binary min-heap block
// operation and status codes, beat layouts, controller/datapath interface structs
// no dependencies
`default_nettype none

package bmh_pkg;

  localparam int FUNC_W  = 2;
  localparam int KEY_W   = 32;
  localparam int SLOT_W  = 4;
  localparam int STAT_W  = 3;
  localparam int CNT_W   = 5;
  localparam int LIMIT_W = 5;

  // input beat: func, key_value, slot_index from bit 0 up, zero padded to 40
  localparam int IN_W      = 40;
  localparam int FUNC_LSB  = 0;
  localparam int KEY_LSB   = FUNC_LSB + FUNC_W;
  localparam int SLOT_LSB  = KEY_LSB + KEY_W;

  // output beat: min_value, status, count from bit 0 up
  localparam int OUT_W     = 40;
  localparam int MIN_LSB   = 0;
  localparam int STAT_LSB  = MIN_LSB + KEY_W;
  localparam int CNT_LSB   = STAT_LSB + STAT_W;

  localparam logic [FUNC_W-1:0] FN_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_EXTRACT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DECR    = 2'd2;
  localparam logic [FUNC_W-1:0] FN_DELETE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADIDX = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTDEC = 3'd4;

  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_START   = 4'd1,
    CMD_UP_RD   = 4'd2,
    CMD_UP_MOVE = 4'd3,
    CMD_WR_CUR  = 4'd4,
    CMD_NOT_DEC = 4'd5,
    CMD_TAKE    = 4'd6,
    CMD_DN_LOAD = 4'd7,
    CMD_DN_RDL  = 4'd8,
    CMD_DN_RDR  = 4'd9,
    CMD_DN_MOVE = 4'd10,
    CMD_OUT     = 4'd11
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic in_ready;
  } ctrl_t;

  typedef struct packed {
    logic              in_valid;
    logic [FUNC_W-1:0] new_func;   // func of the beat on the input
    logic [FUNC_W-1:0] func;       // func of the item in work
    logic              early;      // result known at accept, heap untouched
    logic              at_root;
    logic              parent_le;  // parent key <= moving key
    logic              not_dec;
    logic              cnt_zero;
    logic              has_left;
    logic              child_lt;   // smaller child < moving key
    logic              out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/bmh_dpath.sv -----
// bmh_dpath: key memory, count, sift registers, size limit and output register
// carries out the commands of bmh_ctrl and reports compare results back
// depends on bmh_pkg
`default_nettype none

module bmh_dpath #(
  parameter int DEPTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  input  wire logic [bmh_pkg::IN_W-1:0] s_tdata,
  input  wire logic                    m_tready,
  output logic                         m_tvalid,
  output logic [bmh_pkg::OUT_W-1:0]    m_tdata,
  input  wire logic                    cfg_wen,
  input  wire logic [bmh_pkg::LIMIT_W-1:0] cfg_wdata,
  input  wire bmh_pkg::ctrl_t          ctrl,
  output bmh_pkg::sts_t                sts
);
  import bmh_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;
  localparam int LW = CW + LIMIT_W;
  localparam int SW = CW + SLOT_W;

  logic signed [KEY_W-1:0] mem [DEPTH];
  logic signed [KEY_W-1:0] rdata;
  logic signed [KEY_W-1:0] cur;
  logic signed [KEY_W-1:0] lval;
  logic signed [KEY_W-1:0] minv;
  logic [STAT_W-1:0]       stat;
  logic [FUNC_W-1:0]       func;
  logic [AW-1:0]           pos;
  logic [CW-1:0]           cnt;
  logic                    has_r;
  logic [LIMIT_W-1:0]      size_limit;

  logic [FUNC_W-1:0]       in_func;
  logic signed [KEY_W-1:0] in_key;
  logic [SLOT_W-1:0]       in_slot;
  logic                    is_full;
  logic                    bad_slot;
  logic [AW-1:0]           parent;
  logic [XW-1:0]           lc_x;
  logic [XW-1:0]           rc_x;
  logic [XW-1:0]           cnt_x;
  logic                    best_right;
  logic signed [KEY_W-1:0] best_val;
  logic [AW-1:0]           best_idx;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_data;

  assign in_func = s_tdata[FUNC_LSB +: FUNC_W];
  assign in_key  = s_tdata[KEY_LSB +: KEY_W];
  assign in_slot = s_tdata[SLOT_LSB +: SLOT_W];

  assign is_full  = (LW'(cnt) >= LW'(size_limit)) || (cnt == CW'(DEPTH));
  assign bad_slot = SW'(in_slot) >= SW'(cnt);

  assign parent = (pos - AW'(1)) >> 1;
  assign lc_x   = {1'b0, pos, 1'b1};
  assign rc_x   = lc_x + XW'(1);
  assign cnt_x  = XW'(cnt);

  assign best_right = has_r && (rdata < lval);
  assign best_val   = best_right ? rdata : lval;
  assign best_idx   = best_right ? rc_x[AW-1:0] : lc_x[AW-1:0];

  always_comb begin
    sts.in_valid  = s_tvalid;
    sts.new_func  = in_func;
    sts.func      = func;
    sts.early     = 1'b0;
    case (in_func)
      FN_INSERT:  sts.early = is_full;
      FN_EXTRACT: sts.early = (cnt == '0);
      default:    sts.early = bad_slot;
    endcase
    sts.at_root   = (pos == '0);
    sts.parent_le = (rdata <= cur);
    sts.not_dec   = (cur > rdata);
    sts.cnt_zero  = (cnt == '0);
    sts.has_left  = (lc_x < cnt_x);
    sts.child_lt  = (best_val < cur);
    sts.out_free  = !m_tvalid || m_tready;
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = cur;
    case (ctrl.cmd)
      CMD_START: begin
        rd_en   = 1'b1;
        rd_addr = (in_func == FN_EXTRACT) ? '0 : AW'(in_slot);
      end
      CMD_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = parent;
      end
      CMD_UP_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rdata;
      end
      CMD_WR_CUR: begin
        wr_en   = 1'b1;
      end
      CMD_TAKE: begin
        rd_en   = 1'b1;
        rd_addr = AW'(cnt - CW'(1));
      end
      CMD_DN_RDL: begin
        rd_en   = 1'b1;
        rd_addr = lc_x[AW-1:0];
      end
      CMD_DN_RDR: begin
        rd_en   = 1'b1;
        rd_addr = rc_x[AW-1:0];
      end
      CMD_DN_MOVE: begin
        wr_en   = 1'b1;
        wr_data = best_val;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // sift registers and item result, no reset needed
  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_START: begin
        func <= in_func;
        cur  <= (in_func == FN_DELETE) ? KEY_MIN : in_key;
        pos  <= (in_func == FN_INSERT) ? AW'(cnt) : AW'(in_slot);
        case (in_func)
          FN_INSERT: begin
            minv <= '0;
            stat <= is_full ? ST_FULL : ST_OK;
          end
          FN_EXTRACT: begin
            minv <= (cnt == '0) ? KEY_MAX : '0;
            stat <= (cnt == '0) ? ST_EMPTY : ST_OK;
          end
          default: begin
            minv <= '0;
            stat <= bad_slot ? ST_BADIDX : ST_OK;
          end
        endcase
      end
      CMD_UP_MOVE: begin
        pos <= parent;
      end
      CMD_NOT_DEC: begin
        stat <= ST_NOTDEC;
      end
      CMD_TAKE: begin
        if (func == FN_EXTRACT) begin
          minv <= rdata;
        end
      end
      CMD_DN_LOAD: begin
        cur <= rdata;
        pos <= '0;
      end
      CMD_DN_RDR: begin
        lval  <= rdata;
        has_r <= rc_x < cnt_x;
      end
      CMD_DN_MOVE: begin
        pos <= best_idx;
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      size_limit <= LIMIT_RESET;
    end else begin
      if (cfg_wen) begin
        size_limit <= cfg_wdata;
      end
      if (ctrl.cmd == CMD_START && in_func == FN_INSERT && !is_full) begin
        cnt <= cnt + CW'(1);
      end else if (ctrl.cmd == CMD_TAKE) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // output register, next item can be taken while a beat waits here
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.cmd == CMD_OUT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmd == CMD_OUT) begin
      m_tdata <= {CNT_W'(cnt), stat, minv};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bmh_ctrl.sv -----
// bmh_ctrl: sequencer for insert, extract, decrease and delete
// steps sift-up and sift-down one tree level at a time through bmh_dpath
// depends on bmh_pkg
`default_nettype none

module bmh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bmh_pkg::sts_t sts,
  output bmh_pkg::ctrl_t     ctrl
);
  import bmh_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_UP_RD   = 12'b0000_0000_0010,
    S_UP_CMP  = 12'b0000_0000_0100,
    S_UP_END  = 12'b0000_0000_1000,
    S_EX_ROOT = 12'b0000_0001_0000,
    S_DN_LOAD = 12'b0000_0010_0000,
    S_DN_RDL  = 12'b0000_0100_0000,
    S_DN_RDR  = 12'b0000_1000_0000,
    S_DN_CMP  = 12'b0001_0000_0000,
    S_DN_END  = 12'b0010_0000_0000,
    S_DEC_CHK = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctrl.cmd      = CMD_NONE;
    ctrl.in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (sts.in_valid) begin
          ctrl.cmd = CMD_START;
          if (sts.early) begin
            state_next = S_DONE;
          end else if (sts.new_func == FN_EXTRACT) begin
            state_next = S_EX_ROOT;
          end else if (sts.new_func == FN_DECR) begin
            state_next = S_DEC_CHK;
          end else begin
            state_next = S_UP_RD;
          end
        end
      end
      S_DEC_CHK: begin
        if (sts.not_dec) begin
          ctrl.cmd   = CMD_NOT_DEC;
          state_next = S_DONE;
        end else begin
          state_next = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (sts.at_root) begin
          state_next = S_UP_END;
        end else begin
          ctrl.cmd   = CMD_UP_RD;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.parent_le) begin
          state_next = S_UP_END;
        end else begin
          ctrl.cmd   = CMD_UP_MOVE;
          state_next = S_UP_RD;
        end
      end
      S_UP_END: begin
        ctrl.cmd = CMD_WR_CUR;
        // delete has floated its slot to the root, now drop the root
        state_next = (sts.func == FN_DELETE) ? S_EX_ROOT : S_DONE;
      end
      S_EX_ROOT: begin
        ctrl.cmd   = CMD_TAKE;
        state_next = S_DN_LOAD;
      end
      S_DN_LOAD: begin
        ctrl.cmd   = CMD_DN_LOAD;
        state_next = sts.cnt_zero ? S_DONE : S_DN_RDL;
      end
      S_DN_RDL: begin
        if (sts.has_left) begin
          ctrl.cmd   = CMD_DN_RDL;
          state_next = S_DN_RDR;
        end else begin
          state_next = S_DN_END;
        end
      end
      S_DN_RDR: begin
        ctrl.cmd   = CMD_DN_RDR;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.child_lt) begin
          ctrl.cmd   = CMD_DN_MOVE;
          state_next = S_DN_RDL;
        end else begin
          state_next = S_DN_END;
        end
      end
      S_DN_END: begin
        ctrl.cmd   = CMD_WR_CUR;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctrl.cmd   = CMD_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/binary_min_heap.sv -----
// Binary min-heap of signed 32-bit keys held in a single-port-read key memory of DEPTH
// entries. Each input beat carries one operation (insert, extract-min, decrease-key,
// delete at slot) and gives exactly one output beat with the extracted key, a status
// code and the key count. Items are worked one at a time; the key memory has one
// registered read port, so a sift-up reads the parent and then compares and moves for each
// tree level climbed, and a sift-down reads the left child, reads the right child, then
// compares and moves for each level descended. Delete runs the sift-up path and then the
// extract path. The number of levels moved is at most log2(DEPTH). Full, empty and
// bad-slot items go straight to the result without touching the heap, and a refused
// decrease goes there after its check; a result still waiting on the output stalls the
// next item's last step.
// The next item is taken while the previous result still waits on the output.
// size_limit may be written only while the block is idle.
// depends on bmh_pkg, bmh_ctrl, bmh_dpath
`default_nettype none

module binary_min_heap #(
  parameter int DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // func[1:0], key_value[33:2], slot_index[37:34], zero[39:38]
  input  wire logic [bmh_pkg::IN_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // min_value[31:0], status[34:32], count[39:35]
  output logic [bmh_pkg::OUT_W-1:0]         m_tdata,
  input  wire logic                         cfg_wen,
  input  wire logic [bmh_pkg::LIMIT_W-1:0]  cfg_wdata
);
  import bmh_pkg::*;

  ctrl_t ctrl;
  sts_t  sts;

  bmh_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .sts  (sts),
    .ctrl (ctrl)
  );

  bmh_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .ctrl      (ctrl),
    .sts       (sts)
  );

  assign s_tready = ctrl.in_ready;

  logic signed [KEY_W-1:0] out_min;
  logic [STAT_W-1:0]       out_stat;
  logic [CNT_W-1:0]        out_cnt;

  assign out_min  = m_tdata[MIN_LSB +: KEY_W];
  assign out_stat = m_tdata[STAT_LSB +: STAT_W];
  assign out_cnt  = m_tdata[CNT_LSB +: CNT_W];

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in work");

  // an empty extract reports the largest key and an empty heap
  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_stat == ST_EMPTY) |-> (out_min == KEY_MAX && out_cnt == '0))
    else $error("empty status with wrong key or count");

  // rejected operations give a zero key
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_stat == ST_FULL || out_stat == ST_BADIDX ||
                  out_stat == ST_NOTDEC)) |-> (out_min == '0))
    else $error("rejected operation with nonzero key");

  // a result beat is only loaded from the final step of an item
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    (ctrl.cmd == CMD_OUT) |=> (m_tvalid && s_tready))
    else $error("result load without return to idle");

endmodule

`default_nettype wire
